/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the character LCD nibble writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is released.
`define CLCDW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that an antecedent in one cycle implies a consequent in the next.
`define CLCDW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/clcdw_pkg.sv */
// Package with the types, constants and remap function of the LCD nibble writer.
`default_nettype none

package clcdw_pkg;

  typedef enum logic [1:0] {
    REQ_TEXT    = 2'd0,
    REQ_SET_POS = 2'd1,
    REQ_RAW_CMD = 2'd2,
    REQ_RAW_DAT = 2'd3
  } req_type_e;

  localparam logic [7:0] WrapColumn = 8'd8;
  localparam logic [7:0] Row0Base   = 8'h80;
  localparam logic [7:0] Row1Base   = 8'hC0;
  localparam logic [7:0] GlyphFirst = 8'd192;
  localparam logic [7:0] GlyphLast  = 8'd223;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] GlyphMap [32] = '{
    8'd65,  8'd3,  8'd66, 8'd59, 8'd63, 8'd69, 8'd93, 8'd51,
    8'd123, 8'd64, 8'd75, 8'd6,  8'd77, 8'd72, 8'd79, 8'd92,
    8'd80,  8'd67, 8'd84, 8'd96, 8'd36, 8'd88, 8'd5,  8'd7,
    8'd91,  8'd95, 8'd3,  8'd105, 8'd4, 8'd2,  8'd1,  8'd0
  };

  // One classified item: the byte to send, its register select, and
  // whether a move-to-second-row command follows it.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       rs;
    logic       wrap;
  } job_t;

  function automatic logic [7:0] remap_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == 8'd178) begin
      r = 8'd73;
    end else if (c == 8'd175) begin
      r = 8'd3;
    end else if (c == 8'd170) begin
      r = 8'd2;
    end else if (c >= GlyphFirst && c <= GlyphLast) begin
      r = GlyphMap[c[4:0]];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/clcdw_if.sv */
// Handshake interfaces for the request and nibble channels.
`default_nettype none

interface clcdw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] code;
  logic [5:0] column;
  logic       row;
  logic       wrap_enable;

  modport source (output valid, req_type, code, column, row, wrap_enable, input ready);
  modport sink   (input valid, req_type, code, column, row, wrap_enable, output ready);
endinterface

interface clcdw_nib_if;
  logic       valid;
  logic       ready;
  logic [3:0] nibble;
  logic       reg_select;
  logic       last;

  modport source (output valid, nibble, reg_select, last, input ready);
  modport sink   (input valid, nibble, reg_select, last, output ready);
endinterface

`default_nettype wire

/* rtl/clcdw_front.sv */
// Front end: accepts requests, tracks the cursor and classifies each item.
`default_nettype none
`include "assert_macros.svh"

module clcdw_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  clcdw_req_if.sink          req,
  input  wire logic          full_i,
  output logic               push_o,
  output clcdw_pkg::job_t    job_o
);

  logic [7:0] col_q, col_d, col_inc;
  logic       row_q, row_d;
  logic       wrap;

  assign req.ready = !full_i;
  assign push_o    = req.valid && !full_i;
  assign col_inc   = col_q + 8'd1;
  assign wrap      = !row_q && (col_inc == clcdw_pkg::WrapColumn) && req.wrap_enable;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    job_o = '{data_byte: req.code, rs: 1'b0, wrap: 1'b0};
    case (clcdw_pkg::req_type_e'(req.req_type))
      clcdw_pkg::REQ_TEXT: begin
        job_o.data_byte = clcdw_pkg::remap_char(req.code);
        job_o.rs        = 1'b1;
        job_o.wrap      = wrap;
        col_d           = wrap ? 8'd0 : col_inc;
        row_d           = wrap ? 1'b1 : row_q;
      end
      clcdw_pkg::REQ_SET_POS: begin
        job_o.data_byte = (req.row ? clcdw_pkg::Row1Base : clcdw_pkg::Row0Base)
                          | {2'b00, req.column};
        col_d           = {2'b00, req.column};
        row_d           = req.row;
      end
      clcdw_pkg::REQ_RAW_CMD: begin
        job_o.rs = 1'b0;
      end
      default: begin
        job_o.rs = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 8'd0;
      row_q <= 1'b0;
    end else if (push_o) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  `CLCDW_ASSERT_NEXT(a_wrap_moves_cursor, clk_i, rst_ni, push_o && job_o.wrap, row_q && (col_q == 8'd0), "wrap did not move the cursor to the start of the second row")

endmodule

`default_nettype wire

/* rtl/clcdw_queue.sv */
// Short queue of classified items between the front and back ends.
`default_nettype none
`include "assert_macros.svh"

module clcdw_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire clcdw_pkg::job_t job_i,
  input  wire logic            pop_i,
  output clcdw_pkg::job_t      job_o,
  output logic                 empty_o,
  output logic                 full_o
);

  localparam int unsigned PtrW = $clog2(clcdw_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(clcdw_pkg::QueueDepth + 1);

  clcdw_pkg::job_t entries_q [clcdw_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(clcdw_pkg::QueueDepth));
  assign job_o   = entries_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(clcdw_pkg::QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `CLCDW_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && full_o), "item pushed into a full queue")
  `CLCDW_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && empty_o), "item popped from an empty queue")

endmodule

`default_nettype wire

/* rtl/clcdw_back.sv */
// Back end: splits each queued item into nibble writes through an output register.
`default_nettype none
`include "assert_macros.svh"

module clcdw_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire clcdw_pkg::job_t job_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  clcdw_nib_if.source          nib
);

  logic [1:0] phase_q;
  logic       out_valid_q;
  logic [3:0] nibble_q, nibble_d;
  logic       rs_q, rs_d;
  logic       last_q, last_d;
  logic       advance, fire;

  assign advance = !out_valid_q || nib.ready;
  assign fire    = advance && !empty_i;
  assign pop_o   = fire && last_d;

  always_comb begin
    case (phase_q)
      2'd0: begin
        nibble_d = job_i.data_byte[7:4];
        rs_d     = job_i.rs;
        last_d   = 1'b0;
      end
      2'd1: begin
        nibble_d = job_i.data_byte[3:0];
        rs_d     = job_i.rs;
        last_d   = !job_i.wrap;
      end
      2'd2: begin
        nibble_d = clcdw_pkg::Row1Base[7:4];
        rs_d     = 1'b0;
        last_d   = 1'b0;
      end
      default: begin
        nibble_d = clcdw_pkg::Row1Base[3:0];
        rs_d     = 1'b0;
        last_d   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= !empty_i;
      if (fire) begin
        phase_q <= last_d ? 2'd0 : phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      nibble_q <= nibble_d;
      rs_q     <= rs_d;
      last_q   <= last_d;
    end
  end

  assign nib.valid      = out_valid_q;
  assign nib.nibble     = nibble_q;
  assign nib.reg_select = rs_q;
  assign nib.last       = last_q;

  `CLCDW_ASSERT(a_mid_item_has_job, clk_i, rst_ni, (phase_q == 2'd0) || !empty_i, "part-sent item vanished from the queue")
  `CLCDW_ASSERT(a_wrap_phase_needs_wrap, clk_i, rst_ni, !phase_q[1] || job_i.wrap, "row move nibble issued for an item without wrap")

endmodule

`default_nettype wire

/* rtl/char_lcd_text_nibble_writer_core.sv */
// Top level of the character LCD 4-bit nibble writer.
`default_nettype none

// This block turns display requests (text characters, set-position requests,
// raw command bytes and raw data bytes) into the nibble writes of a character
// LCD running in 4-bit mode: each byte leaves as its high nibble followed by
// its low nibble, both carrying the same register-select bit, and the final
// nibble of every item is flagged with last. Text characters are remapped
// first, through three fixed substitutions and a 32-entry glyph table for
// codes 192 to 223. The block keeps a cursor column and row; text that reaches
// the wrap column on the top row with wrap_enable set is followed by a command
// that moves the display to the start of the second row. The front end takes
// one item per cycle whenever its two-entry queue has room, and the back end
// issues one nibble per cycle into an output register unless the nibble port
// holds it off, so an ordinary item takes two nibble writes on the port and a
// wrapping text character four; that port sets the sustained rate. An accepted
// item is written into the queue first, and its first nibble is then loaded
// into the output register from the queue head. There is no clearing pass
// after reset.
module char_lcd_text_nibble_writer_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  clcdw_req_if.sink   req,
  clcdw_nib_if.source nib
);

  clcdw_pkg::job_t push_job, head_job;
  logic            push, pop, q_empty, q_full;

  // Front end: cursor tracking and classification of each accepted item.
  clcdw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .full_i (q_full),
    .push_o (push),
    .job_o  (push_job)
  );

  // Queue: decouples acceptance from nibble output so either side may stall.
  clcdw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back end: sequences two or four nibbles per item into the output register.
  clcdw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (head_job),
    .empty_i (q_empty),
    .pop_o   (pop),
    .nib     (nib)
  );

endmodule

`default_nettype wire
